>>> design/pid_steering_controller_macros.svh
// Assertion macros shared by the steering controller RTL.
`ifndef PID_STEERING_CONTROLLER_MACROS_SVH
`define PID_STEERING_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("steering controller assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("steering controller assertion failed");

`endif

>>> design/psc_pkg.sv
// Package with the widths, limits and register indexes of the steering controller.
`timescale 1ns / 1ps

package psc_pkg;

    localparam int DEFAULT_SUM_WIDTH = 32;
    localparam int DEFAULT_FRAC_BITS = 24;

    localparam int LEVEL_W     = 7;
    localparam int GAIN_W      = 32;
    localparam int TURN_W      = 16;
    localparam int ERR_W       = 9;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Product widths: gain times a 9-bit error, and gain times the sum magnitude,
    // the latter split into a 32-bit low part and a 16-bit high part.
    localparam int PROD_W      = GAIN_W + ERR_W + 1;
    localparam int MAG_MAX_W   = 48;
    localparam int MAG_LO_W    = 32;
    localparam int MAG_HI_W    = MAG_MAX_W - MAG_LO_W;
    localparam int IPROD_W     = GAIN_W + MAG_MAX_W;
    localparam int TOTAL_W     = 64;
    localparam int ITERM_LIMIT_LOG2 = 62;

    localparam logic signed [TURN_W-1:0] INT16_HIGHEST = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] INT16_LOWEST  = 16'sh8000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_LEVEL = 3'd0,
        REG_P_GAIN       = 3'd1,
        REG_I_GAIN       = 3'd2,
        REG_D_GAIN       = 3'd3,
        REG_TURN_UPPER   = 3'd4,
        REG_TURN_LOWER   = 3'd5,
        REG_TRACE_LEFT   = 3'd6
    } cfg_reg_t;

endpackage

>>> design/pid_steering_controller.sv
// Top level of the PID steering controller with trapezoidal integral.
//
// One input beat carries a reflected-light sample; each one yields exactly one
// result beat with the steering amount and a flag that tells whether the value
// was saturated or clamped. Both channels use valid/ready handshakes.
// The loop state (previous error and the saturating error sum) is updated in the
// cycle the input beat is accepted, so samples may arrive on consecutive cycles.
// The remaining work runs through a five-register pipeline: error and sum, the
// gain multiplies, the integral limit, the final add, and the output register.
// Each result beat passes through the five registers in order, and the block
// sustains one beat per cycle while the receiver does not stall.
// When the receiver stalls, results wait in the pipeline and bubbles close up,
// so up to five beats can be held before in_ready falls.
// Reset (rst_n low, asynchronous) empties the pipeline, clears the error state
// and loads the default gains, a target of zero and turn limits of +/-100. The user
// writes configuration via cfg_wr_en/cfg_index/cfg_wdata while idle, unenforced.
`timescale 1ns / 1ps
`include "pid_steering_controller_macros.svh"

module pid_steering_controller
    import psc_pkg::*;
#(
    parameter int SUM_WIDTH = DEFAULT_SUM_WIDTH,
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LEVEL_W-1:0]            reflect_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [TURN_W-1:0]      turn_amount,
    output logic                          limited
);

    // Reset values of the gains follow the fraction width.
    localparam logic [TOTAL_W-1:0] I_GAIN_RESET_WIDE =
        ((64'd1 << FRAC_BITS) * 64'd5 + 64'd5000) / 64'd10000;
    localparam logic [GAIN_W-1:0] P_GAIN_RESET = GAIN_W'(64'd3 << (FRAC_BITS - 1));
    localparam logic [GAIN_W-1:0] I_GAIN_RESET = I_GAIN_RESET_WIDE[GAIN_W-1:0];
    localparam logic [GAIN_W-1:0] D_GAIN_RESET = GAIN_W'(64'd3 << FRAC_BITS);
    localparam logic signed [TURN_W-1:0] TURN_UPPER_RESET = 16'sd100;
    localparam logic signed [TURN_W-1:0] TURN_LOWER_RESET = -16'sd100;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic [IPROD_W-1:0] ITERM_LIMIT = IPROD_W'(1) << ITERM_LIMIT_LOG2;
    localparam logic signed [TOTAL_W-1:0] Q_HI = TOTAL_W'(INT16_HIGHEST);
    localparam logic signed [TOTAL_W-1:0] Q_LO = TOTAL_W'(INT16_LOWEST);
    localparam int PD_W = PROD_W + 1;

    // Configuration registers.
    logic [LEVEL_W-1:0]        target_level_reg;
    logic [GAIN_W-1:0]         p_gain_reg;
    logic [GAIN_W-1:0]         i_gain_reg;
    logic [GAIN_W-1:0]         d_gain_reg;
    logic signed [TURN_W-1:0]  turn_upper_reg;
    logic signed [TURN_W-1:0]  turn_lower_reg;
    logic                      trace_left_reg;

    // Loop state.
    logic signed [ERR_W-1:0]     prev_err_reg;
    logic signed [SUM_WIDTH-1:0] error_sum_reg;

    // Pipeline valid bits and per-stage advance conditions.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic ready2, ready3, ready4, ready5;
    logic accept;

    // Stage payloads.
    logic signed [ERR_W-1:0]     s1_err_reg;
    logic signed [ERR_W-1:0]     s1_diff_reg;
    logic [SUM_WIDTH-1:0]        s1_mag_reg;
    logic                        s1_neg_reg;

    logic signed [PROD_W-1:0]    s2_pterm_reg;
    logic signed [PROD_W-1:0]    s2_dterm_reg;
    logic [2*GAIN_W-1:0]         s2_ilo_reg;
    logic [GAIN_W+MAG_HI_W-1:0]  s2_ihi_reg;
    logic                        s2_neg_reg;

    logic signed [TOTAL_W-1:0]   s3_iterm_reg;
    logic signed [PD_W-1:0]      s3_pd_reg;

    logic signed [TOTAL_W-1:0]   s4_total_reg;

    logic signed [TURN_W-1:0]    turn_reg;
    logic                        limited_reg;

    // Combinational values.
    logic signed [ERR_W-1:0]     err;
    logic signed [ERR_W-1:0]     err_plus_prev;
    logic signed [ERR_W-1:0]     err_diff;
    logic [SUM_WIDTH:0]          sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_next;
    logic [SUM_WIDTH-1:0]        mag_next;

    logic [MAG_MAX_W-1:0]        mag_pad;
    logic signed [PROD_W-1:0]    pterm_next;
    logic signed [PROD_W-1:0]    dterm_next;
    logic [2*GAIN_W-1:0]         ilo_next;
    logic [GAIN_W+MAG_HI_W-1:0]  ihi_next;

    logic [IPROD_W-1:0]          iprod_full;
    logic [TOTAL_W-1:0]          imag;
    logic signed [TOTAL_W-1:0]   iterm_next;
    logic signed [PD_W-1:0]      pd_next;

    logic signed [TOTAL_W-1:0]   total_next;

    logic signed [TURN_W-1:0]    turn_next;
    logic                        limited_next;

    // Handshake: bubbles collapse, so a stalled output does not block entry
    // until every stage is occupied.
    assign ready5   = !s5_valid_reg || out_ready;
    assign ready4   = !s4_valid_reg || ready5;
    assign ready3   = !s3_valid_reg || ready4;
    assign ready2   = !s2_valid_reg || ready3;
    assign in_ready = !s1_valid_reg || ready2;
    assign accept   = in_valid && in_ready;

    assign out_valid   = s5_valid_reg;
    assign turn_amount = turn_reg;
    assign limited     = limited_reg;

    // Entry: error, derivative difference and the saturating trapezoidal sum.
    assign err = $signed({{(ERR_W-LEVEL_W){1'b0}}, target_level_reg})
               - $signed({{(ERR_W-LEVEL_W){1'b0}}, reflect_sample});
    assign err_plus_prev = err + prev_err_reg;
    assign err_diff      = err - prev_err_reg;
    assign sum_wide = {error_sum_reg[SUM_WIDTH-1], error_sum_reg}
                    + {{(SUM_WIDTH+1-ERR_W){err_plus_prev[ERR_W-1]}}, err_plus_prev};

    always_comb
    begin
        case (sum_wide[SUM_WIDTH:SUM_WIDTH-1])
            2'b01:   sum_next = SUM_MAX;
            2'b10:   sum_next = SUM_MIN;
            default: sum_next = $signed(sum_wide[SUM_WIDTH-1:0]);
        endcase
    end

    // The most negative sum gives 2^(SUM_WIDTH-1), which fits unsigned.
    assign mag_next = sum_next[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_next) : SUM_WIDTH'(sum_next);

    // Multiplier stage: the integral product is split into two partial products.
    assign mag_pad    = MAG_MAX_W'(s1_mag_reg);
    assign pterm_next = $signed({1'b0, p_gain_reg}) * s1_err_reg;
    assign dterm_next = $signed({1'b0, d_gain_reg}) * s1_diff_reg;
    assign ilo_next   = i_gain_reg * mag_pad[MAG_LO_W-1:0];
    assign ihi_next   = i_gain_reg * mag_pad[MAG_MAX_W-1:MAG_LO_W];

    // Integral limit: holding the magnitude at 2^62 is exact, since the result
    // saturates to int16 long before that.
    assign iprod_full = {s2_ihi_reg, {MAG_LO_W{1'b0}}} + IPROD_W'(s2_ilo_reg);
    assign imag       = (iprod_full > ITERM_LIMIT) ? TOTAL_W'(ITERM_LIMIT)
                                                   : iprod_full[TOTAL_W-1:0];
    assign iterm_next = s2_neg_reg ? -$signed(imag) : $signed(imag);
    assign pd_next    = {s2_pterm_reg[PROD_W-1], s2_pterm_reg}
                      + {s2_dterm_reg[PROD_W-1], s2_dterm_reg};

    assign total_next = s3_iterm_reg + {{(TOTAL_W-PD_W){s3_pd_reg[PD_W-1]}}, s3_pd_reg};

    // Output stage: truncate toward zero, saturate, clamp and apply the side sign.
    always_comb
    begin
        logic signed [TOTAL_W-1:0] q_floor;
        logic signed [TOTAL_W-1:0] q;
        logic                      round_up;
        logic signed [TURN_W-1:0]  c;
        logic                      lim;

        q_floor  = s4_total_reg >>> FRAC_BITS;
        round_up = s4_total_reg[TOTAL_W-1] && (|s4_total_reg[FRAC_BITS-1:0]);
        q        = q_floor + $signed({{(TOTAL_W-1){1'b0}}, round_up});
        lim      = 1'b0;

        if (q > Q_HI)
        begin
            c   = INT16_HIGHEST;
            lim = 1'b1;
        end
        else if (q < Q_LO)
        begin
            c   = INT16_LOWEST;
            lim = 1'b1;
        end
        else
        begin
            c = $signed(q[TURN_W-1:0]);
        end

        // Crossed limits: a value above upper takes upper, else it takes lower.
        if (c > turn_upper_reg)
        begin
            c   = turn_upper_reg;
            lim = 1'b1;
        end
        else if (c < turn_lower_reg)
        begin
            c   = turn_lower_reg;
            lim = 1'b1;
        end

        if (trace_left_reg)
        begin
            if (c == INT16_LOWEST)
            begin
                c   = INT16_HIGHEST;
                lim = 1'b1;
            end
            else
            begin
                c = -c;
            end
        end

        turn_next    = c;
        limited_next = lim;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_level_reg <= '0;
            p_gain_reg       <= P_GAIN_RESET;
            i_gain_reg       <= I_GAIN_RESET;
            d_gain_reg       <= D_GAIN_RESET;
            turn_upper_reg   <= TURN_UPPER_RESET;
            turn_lower_reg   <= TURN_LOWER_RESET;
            trace_left_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET_LEVEL: target_level_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_P_GAIN:       p_gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_I_GAIN:       i_gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_D_GAIN:       d_gain_reg       <= cfg_wdata[GAIN_W-1:0];
                REG_TURN_UPPER:   turn_upper_reg   <= $signed(cfg_wdata[TURN_W-1:0]);
                REG_TURN_LOWER:   turn_lower_reg   <= $signed(cfg_wdata[TURN_W-1:0]);
                REG_TRACE_LEFT:   trace_left_reg   <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Loop state and pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg  <= '0;
            error_sum_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_err_reg  <= err;
                error_sum_reg <= sum_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (ready5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Stage payloads carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_err_reg  <= err;
            s1_diff_reg <= err_diff;
            s1_mag_reg  <= mag_next;
            s1_neg_reg  <= sum_next[SUM_WIDTH-1];
        end
        if (ready2)
        begin
            s2_pterm_reg <= pterm_next;
            s2_dterm_reg <= dterm_next;
            s2_ilo_reg   <= ilo_next;
            s2_ihi_reg   <= ihi_next;
            s2_neg_reg   <= s1_neg_reg;
        end
        if (ready3)
        begin
            s3_iterm_reg <= iterm_next;
            s3_pd_reg    <= pd_next;
        end
        if (ready4)
        begin
            s4_total_reg <= total_next;
        end
        if (ready5)
        begin
            turn_reg    <= turn_next;
            limited_reg <= limited_next;
        end
    end

    // An empty entry stage always takes a beat.
    `PSC_ASSERT_NOW(a_entry_free, clk, rst_n, !s1_valid_reg, in_ready)
    // With every stage occupied and the receiver stalled, nothing more enters.
    `PSC_ASSERT_NOW(a_full_blocks, clk, rst_n,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && s5_valid_reg
        && !out_ready, !in_ready)
    // A beat in the entry stage moves on when the next stage is empty.
    `PSC_ASSERT_NEXT(a_bubble_closes, clk, rst_n, s1_valid_reg && !s2_valid_reg,
        s2_valid_reg)
    // A result only appears when the stage before it held a beat.
    `PSC_ASSERT_NOW(a_out_from_s4, clk, rst_n, $rose(out_valid), $past(s4_valid_reg))

endmodule
